// ----- design/vzs_pkg.sv -----
// Shared types, constants and a helper function of the valve zone sequencer.
`timescale 1ns / 1ps
package vzs_pkg;

   // Default values of the top-level parameters.
   localparam int ZONE_COUNT_DEF    = 8;
   localparam int TICKS_PER_SEC_DEF = 25;

   // Fixed constants of the behaviour.
   localparam logic [3:0]  NO_ZONE        = 4'hF;
   localparam logic [5:0]  FADE_TICKS     = 6'd50;
   localparam logic [3:0]  BLINK_STEPS    = 4'd8;
   localparam logic [14:0] DELAY_MAX      = 15'h7FFF;
   localparam logic [9:0]  DELAY_SEC_RST  = 10'd5;

   // Request mode codes.
   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_ZONE   = 3'd1;
   localparam logic [2:0] MODE_MASTER = 3'd2;
   localparam logic [2:0] MODE_SHORT  = 3'd3;
   localparam logic [2:0] MODE_LONG   = 3'd4;

   // Classified operations passed from the front end to the back end.
   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_TICK   = 3'd1,
      OP_ZONE   = 3'd2,
      OP_TOGGLE = 3'd3,
      OP_MASTER = 3'd4,
      OP_LONG   = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] zone_index;
      logic       zone_on;
      logic [3:0] master_number;
   } req_type;

   typedef struct packed {
      logic       led_update;
      logic [7:0] red_mask;
      logic [7:0] green_mask;
      logic [7:0] zones_turned_on;
      logic [7:0] zones_turned_off;
      logic       master_changed;
      logic [3:0] new_master;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] zone;
      logic       on;
      logic [3:0] number;
   } cmd_type;

   // Brightness level of the fade: the remaining ticks divided by five, taken
   // as a multiplication by 13/64, which is exact over the fade range.
   function automatic logic [3:0] fade_level(input logic [5:0] left);
      logic [9:0] scaled;
      scaled     = 10'(left) * 10'd13;
      fade_level = scaled[9:6];
   endfunction

endpackage

// ----- design/vzs_front.sv -----
// Front end: accepts requests, classifies them and holds them in a short queue.
`timescale 1ns / 1ps
module vzs_front #(
   parameter int ZONE_COUNT = vzs_pkg::ZONE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  vzs_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output vzs_pkg::cmd_type  cmd
);
   import vzs_pkg::*;

   cmd_type    class_cmd;
   cmd_type    entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       zone_ok;
   logic       number_ok;
   logic       wr_en;
   logic       rd_en;

   // Range checks on the request fields.
   assign zone_ok   = {1'b0, req_data.zone_index} < 4'(ZONE_COUNT);
   assign number_ok = {1'b0, req_data.master_number} <= 5'(ZONE_COUNT);

   // Classify the request; anything out of range becomes a no-op.
   always_comb begin
      class_cmd.op     = OP_NOP;
      class_cmd.zone   = req_data.zone_index;
      class_cmd.on     = req_data.zone_on;
      class_cmd.number = req_data.master_number;
      case (req_data.mode)
         MODE_TICK: begin
            class_cmd.op = OP_TICK;
         end
         MODE_ZONE: begin
            if (zone_ok) class_cmd.op = OP_ZONE;
         end
         MODE_MASTER: begin
            if (number_ok) class_cmd.op = OP_MASTER;
         end
         MODE_SHORT: begin
            if (zone_ok) class_cmd.op = OP_TOGGLE;
         end
         MODE_LONG: begin
            if (zone_ok) class_cmd.op = OP_LONG;
         end
         default: begin
            class_cmd.op = OP_NOP;
         end
      endcase
   end

   // Two-entry queue towards the back end.
   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign wr_en     = push && !full;
   assign rd_en     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_ff[wr_ptr_ff] <= class_cmd;
   end

endmodule

// ----- design/vzs_rsp_queue.sv -----
// Result queue: holds finished results until the consumer pops them.
`timescale 1ns / 1ps
module vzs_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  vzs_pkg::rsp_type  wr_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output vzs_pkg::rsp_type  rsp_data
);
   import vzs_pkg::*;

   rsp_type    entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_en;
   logic       rd_en;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_data = entry_ff[rd_ptr_ff];
   assign wr_en    = wr && !full;
   assign rd_en    = pop && !empty;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// ----- design/vzs_back.sv -----
// Back end: zone state, master handling and the per-tick zone scan.
`timescale 1ns / 1ps
module vzs_back #(
   parameter int ZONE_COUNT    = vzs_pkg::ZONE_COUNT_DEF,
   parameter int TICKS_PER_SEC = vzs_pkg::TICKS_PER_SEC_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  vzs_pkg::cmd_type  cmd,
   input  logic              rsp_full,
   output logic              rsp_push,
   output vzs_pkg::rsp_type  rsp_out,
   input  logic              csr_wen,
   input  logic [9:0]        csr_wdata
);
   import vzs_pkg::*;

   localparam int ZW = $clog2(ZONE_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_LEDS = 3'b100
   } back_state_type;

   back_state_type  state_ff, state_in;
   logic [9:0]      delay_sec_ff;
   logic [ZONE_COUNT-1:0] active_ff, active_in;
   logic [ZONE_COUNT-1:0] waiting_ff, waiting_in;
   logic [14:0]     delay_ff [ZONE_COUNT];
   logic [14:0]     delay_in [ZONE_COUNT];
   logic [3:0]      master_ff, master_in;
   logic [3:0]      fb_ff, fb_in;
   logic [5:0]      fade_ff, fade_in;
   logic [3:0]      blink_ff, blink_in;
   logic [31:0]     flash_ff, flash_in;
   logic [3:0]      mod10_ff, mod10_in;
   logic [2:0]      mod6_ff, mod6_in;
   logic [ZW-1:0]   scan_ff, scan_in;
   logic            run_ff, run_in;
   logic            wait_ff, wait_in;
   logic [7:0]      on_acc_ff, on_acc_in;

   logic [ZW-1:0]   cz;
   logic [16:0]     delay_full;
   logic [14:0]     delay_load;
   logic            do_switch;
   logic            sw_on;
   logic            do_assign;
   logic [3:0]      nm;
   logic            scan_active;
   logic [7:0]      red_v;
   logic [7:0]      green_v;
   logic [ZW-1:0]   fz;
   logic            fb_live;

   assign cz = cmd.zone[ZW-1:0];
   assign fz = fb_ff[ZW-1:0];

   // Delay load in ticks, saturated to the counter range.
   assign delay_full = 17'(delay_sec_ff) * 17'(TICKS_PER_SEC);
   assign delay_load = (delay_full > 17'(DELAY_MAX)) ? DELAY_MAX : delay_full[14:0];

   // Command execution and the tick sequencer.
   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      waiting_in  = waiting_ff;
      delay_in    = delay_ff;
      master_in   = master_ff;
      fb_in       = fb_ff;
      fade_in     = fade_ff;
      blink_in    = blink_ff;
      flash_in    = flash_ff;
      mod10_in    = mod10_ff;
      mod6_in     = mod6_ff;
      scan_in     = scan_ff;
      run_in      = run_ff;
      wait_in     = wait_ff;
      on_acc_in   = on_acc_ff;
      cmd_take    = 1'b0;
      rsp_push    = 1'b0;
      rsp_out     = '0;
      do_switch   = 1'b0;
      sw_on       = 1'b0;
      do_assign   = 1'b0;
      nm          = 4'd0;
      scan_active = 1'b0;
      red_v       = 8'd0;
      green_v     = 8'd0;
      fb_live     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_take = 1'b1;
               case (cmd.op)
                  OP_TICK: begin
                     flash_in = flash_ff + 32'd1;
                     if (flash_ff == '1) begin
                        mod10_in = 4'd0;
                        mod6_in  = 3'd0;
                     end else begin
                        mod10_in = (mod10_ff == 4'd9) ? 4'd0 : mod10_ff + 4'd1;
                        mod6_in  = (mod6_ff == 3'd5) ? 3'd0 : mod6_ff + 3'd1;
                     end
                     run_in    = 1'b0;
                     wait_in   = 1'b0;
                     on_acc_in = 8'd0;
                     scan_in   = '0;
                     state_in  = ST_SCAN;
                  end
                  OP_ZONE: begin
                     do_switch = 1'b1;
                     sw_on     = cmd.on;
                     rsp_push  = 1'b1;
                  end
                  OP_TOGGLE: begin
                     do_switch = 1'b1;
                     sw_on     = !active_ff[cz] && !waiting_ff[cz];
                     rsp_push  = 1'b1;
                  end
                  OP_MASTER: begin
                     do_assign = 1'b1;
                     nm        = cmd.number;
                     rsp_push  = 1'b1;
                  end
                  OP_LONG: begin
                     do_assign = 1'b1;
                     nm        = (master_ff == 4'(cz)) ? 4'd0 : {1'b0, cmd.zone} + 4'd1;
                     rsp_push  = 1'b1;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end

            // Switch a zone on or off.
            if (do_switch) begin
               if (master_ff == 4'(cz)) begin
                  active_in[cz] = sw_on;
               end else if (sw_on) begin
                  if (delay_sec_ff != 10'd0 && master_ff != NO_ZONE) begin
                     waiting_in[cz] = 1'b1;
                     delay_in[cz]   = delay_load;
                     active_in[cz]  = 1'b0;
                  end else begin
                     active_in[cz]  = 1'b1;
                     waiting_in[cz] = 1'b0;
                     rsp_out.zones_turned_on[cz] = 1'b1;
                  end
               end else begin
                  active_in[cz]  = 1'b0;
                  waiting_in[cz] = 1'b0;
                  delay_in[cz]   = 15'd0;
                  rsp_out.zones_turned_off[cz] = 1'b1;
               end
            end

            // Assign or remove the master zone.
            if (do_assign) begin
               fade_in  = 6'd0;
               blink_in = 4'd0;
               rsp_out.master_changed = 1'b1;
               rsp_out.new_master     = nm;
               if (nm == 4'd0) begin
                  if (master_ff != NO_ZONE) begin
                     fb_in    = master_ff;
                     blink_in = BLINK_STEPS;
                  end
                  master_in = NO_ZONE;
               end else begin
                  master_in = nm - 4'd1;
                  fb_in     = nm - 4'd1;
                  fade_in   = FADE_TICKS;
               end
            end
         end

         // Count the delay of one zone per cycle.
         ST_SCAN: begin
            if (master_ff != 4'(scan_ff)) begin
               scan_active = active_ff[scan_ff];
               if (waiting_ff[scan_ff] && delay_ff[scan_ff] != 15'd0) begin
                  wait_in            = 1'b1;
                  delay_in[scan_ff]  = delay_ff[scan_ff] - 15'd1;
                  if (delay_ff[scan_ff] == 15'd1) begin
                     waiting_in[scan_ff] = 1'b0;
                     active_in[scan_ff]  = 1'b1;
                     scan_active         = 1'b1;
                     on_acc_in[scan_ff]  = 1'b1;
                  end
               end
               if (scan_active) run_in = 1'b1;
            end
            if (scan_ff == ZW'(ZONE_COUNT - 1)) begin
               state_in = ST_LEDS;
            end else begin
               scan_in = scan_ff + ZW'(1);
            end
         end

         // Build the LED masks and step the feedback animation.
         ST_LEDS: begin
            for (int i = 0; i < ZONE_COUNT; i++) begin
               if (master_ff == 4'(i)) begin
                  if (active_ff[i] || run_ff || wait_ff) begin
                     red_v[i]   = 1'b1;
                     green_v[i] = 1'b1;
                  end
               end else if (active_ff[i]) begin
                  red_v[i] = 1'b1;
               end else if (waiting_ff[i]) begin
                  green_v[i] = (mod6_ff < 3'd3);
               end
            end
            fb_live = (fb_ff < 4'(ZONE_COUNT)) && !run_ff && !wait_ff && !active_ff[fz];
            if (fb_live) begin
               if (fade_ff != 6'd0) begin
                  green_v[fz] = (mod10_ff < fade_level(fade_ff));
                  fade_in = (master_ff == fb_ff) ? fade_ff - 6'd1 : 6'd0;
               end
               if (blink_ff != 4'd0) begin
                  green_v[fz] = blink_ff[1];
                  if (flash_ff[1:0] == 2'd0) begin
                     blink_in = blink_ff - 4'd1;
                     if (blink_ff == 4'd1) fb_in = NO_ZONE;
                  end
               end
            end
            rsp_push                = 1'b1;
            rsp_out.led_update      = 1'b1;
            rsp_out.red_mask        = red_v;
            rsp_out.green_mask      = green_v;
            rsp_out.zones_turned_on = on_acc_ff;
            state_in                = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_sec_ff <= DELAY_SEC_RST;
         active_ff    <= '0;
         waiting_ff   <= '0;
         for (int i = 0; i < ZONE_COUNT; i++) delay_ff[i] <= 15'd0;
         master_ff    <= NO_ZONE;
         fb_ff        <= NO_ZONE;
         fade_ff      <= 6'd0;
         blink_ff     <= 4'd0;
         flash_ff     <= 32'd0;
         mod10_ff     <= 4'd0;
         mod6_ff      <= 3'd0;
         scan_ff      <= '0;
         run_ff       <= 1'b0;
         wait_ff      <= 1'b0;
         on_acc_ff    <= 8'd0;
      end else begin
         state_ff     <= state_in;
         if (csr_wen) delay_sec_ff <= csr_wdata;
         active_ff    <= active_in;
         waiting_ff   <= waiting_in;
         delay_ff     <= delay_in;
         master_ff    <= master_in;
         fb_ff        <= fb_in;
         fade_ff      <= fade_in;
         blink_ff     <= blink_in;
         flash_ff     <= flash_in;
         mod10_ff     <= mod10_in;
         mod6_ff      <= mod6_in;
         scan_ff      <= scan_in;
         run_ff       <= run_in;
         wait_ff      <= wait_in;
         on_acc_ff    <= on_acc_in;
      end
   end

   // A command is only taken when the result queue has room for its result.
   a_take_room: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> !rsp_full)
      else $error("command taken while result queue full");

   // No result leaves during the zone scan.
   a_no_push_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> state_ff != ST_SCAN)
      else $error("result pushed during scan");

   // The mask stage is only reached from the scan.
   a_leds_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LEDS |-> $past(state_ff) == ST_SCAN)
      else $error("mask stage entered without scan");

   // The fade never exceeds its starting length.
   a_fade_range: assert property (@(posedge clock) disable iff (reset)
      fade_ff <= FADE_TICKS)
      else $error("fade counter out of range");

endmodule

// ----- design/valve_zone_sequencer_led_drive_core.sv -----
// Path: a command's result passes the registered front-end queue and result queue;
// a tick scans one zone per cycle and holds off new requests until its masks are sent.
// Throughput: one command per cycle while the result queue has room and no tick runs.
// Reset: synchronous, clears all zone state, counters and queues.
// After reset the master delay is 5 seconds and no master or feedback zone is set.
// Top level of the valve zone sequencer and LED drive.
`timescale 1ns / 1ps
module valve_zone_sequencer_led_drive_core #(
   parameter int ZONE_COUNT    = vzs_pkg::ZONE_COUNT_DEF,
   parameter int TICKS_PER_SEC = vzs_pkg::TICKS_PER_SEC_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  vzs_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output vzs_pkg::rsp_type  rsp_data,
   input  logic              csr_wen,
   input  logic [9:0]        csr_wdata
);
   import vzs_pkg::*;

   cmd_type cmd;
   rsp_type back_rsp;
   logic    cmd_valid;
   logic    cmd_take;
   logic    rsp_full;
   logic    rsp_push;

   // Request intake and classification.
   vzs_front #(
      .ZONE_COUNT (ZONE_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   // Execution of requests.
   vzs_back #(
      .ZONE_COUNT    (ZONE_COUNT),
      .TICKS_PER_SEC (TICKS_PER_SEC)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_out   (back_rsp),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   // Results waiting for the consumer.
   vzs_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (rsp_push),
      .wr_data  (back_rsp),
      .full     (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
